FILE: rtl/pvfa_pkg.sv
// ----------------------------------------------------------------------------
// pvfa_pkg
// Types, register codes and fixed-point constants shared by the velocity-form
// PID channel.
// ----------------------------------------------------------------------------
`default_nettype none

package pvfa_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned MUL_W     = 33;
	localparam int unsigned PROD_W    = 2 * MUL_W;
	localparam int unsigned PSH_W     = PROD_W - 16;   // product after the Q16 shift
	localparam int unsigned ACC_W     = 54;
	localparam int unsigned DRV_W     = 40;
	localparam int unsigned WRAP_W    = 28;
	localparam int unsigned WCNT_W    = 4;

	// Register codes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KI      = 3'd0,
		REG_KP      = 3'd1,
		REG_KD      = 3'd2,
		REG_LOW     = 3'd3,
		REG_HIGH    = 3'd4,
		REG_POLE    = 3'd5,
		REG_FIN     = 3'd6,
		REG_ANGULAR = 3'd7
	} reg_idx_t;

	// round(pi/180 * 2^32)
	localparam logic signed [MUL_W-1:0] DEG2RAD_Q32 = 33'sd74961321;
	localparam logic [WRAP_W-1:0] PI_Q16     = 28'd205887;
	localparam logic [WRAP_W-1:0] TWO_PI_Q16 = 28'd411775;
	// 2*pi*256, lifts any converted error into the positive range
	localparam logic [WRAP_W-1:0] WRAP_BIAS  = 28'd105414400;
	localparam logic [WCNT_W-1:0] WRAP_TOP   = 4'd8;

	localparam logic signed [DATA_W-1:0] LOW_LIMIT_RST  = -32'sd655360;
	localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RST = 32'sd655360;

	typedef struct packed {
		logic signed [DATA_W-1:0] ki;
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] kd;
		logic signed [DATA_W-1:0] low;
		logic signed [DATA_W-1:0] high;
		logic [16:0]              pole;
		logic [30:0]              fin;
		logic                     angular;
	} cfg_t;

	// One sample as classified by the front end
	typedef struct packed {
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] rate;
		logic signed [DATA_W-1:0] ref_v;
		logic signed [DATA_W-1:0] lin_err;
		logic                     angular;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV_REF,
		ST_CONV_POS,
		ST_CONV_RATE,
		ST_CONV_END,
		ST_WRAP,
		ST_FILT_POLE,
		ST_FILT_IN,
		ST_FILT_SUM,
		ST_MUL_KP,
		ST_MUL_KD,
		ST_FINISH
	} state_t;

	function automatic logic signed [DATA_W-1:0] sat_to_32(input logic [ACC_W-1:0] v);
		logic fits;
		fits = (&v[ACC_W-1:DATA_W-1]) | ~(|v[ACC_W-1:DATA_W-1]);
		if (fits) begin
			return v[DATA_W-1:0];
		end
		return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pvfa_front.sv
// ----------------------------------------------------------------------------
// pvfa_front
// Input side: takes a sample, tags its mode and precomputes the saturated
// linear error, then writes it into the sample queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pvfa_front
	import pvfa_pkg::*;
(
	input  wire logic                     push,
	output logic                          full,
	input  wire logic signed [DATA_W-1:0] measured_value,
	input  wire logic signed [DATA_W-1:0] measured_rate,
	input  wire logic signed [DATA_W-1:0] target_value,
	input  wire logic                     angular,
	input  wire logic                     q_full,
	output logic                          q_wr,
	output item_t                         q_wdata
);

	logic [DATA_W:0] diff;

	assign diff = {target_value[DATA_W-1], target_value}
		- {measured_value[DATA_W-1], measured_value};

	assign full = q_full;
	assign q_wr = push && !q_full;

	always_comb begin
		q_wdata.pos     = measured_value;
		q_wdata.rate    = measured_rate;
		q_wdata.ref_v   = target_value;
		q_wdata.angular = angular;
		if (diff[DATA_W] != diff[DATA_W-1]) begin
			q_wdata.lin_err = diff[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			q_wdata.lin_err = diff[DATA_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pvfa_queue.sv
// ----------------------------------------------------------------------------
// pvfa_queue
// Small register queue of classified samples between front end and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pvfa_queue
	import pvfa_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire item_t wr_data,
	output logic       full,
	input  wire logic  rd_en,
	output item_t      rd_data,
	output logic       valid
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pvfa_back.sv
// ----------------------------------------------------------------------------
// pvfa_back
// Sequencer: unit conversion, angle wrap, acceleration filter and drive
// update around one shared 33x33 multiplier; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvfa_back
	import pvfa_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cfg_t                     cfg,
	input  wire logic                     q_valid,
	input  wire item_t                    q_rdata,
	output logic                          q_rd,
	output logic                          empty,
	input  wire logic                     pop,
	output logic signed [DATA_W-1:0]      drive,
	output logic                          saturated
);

	state_t state_q, state_nxt;

	// Per-sample working registers
	logic signed [DATA_W-1:0] pos_q, rate_q, ref_q, err_q;
	logic [WRAP_W-1:0]        wrap_q;
	logic [WCNT_W-1:0]        wrap_cnt_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	// Channel state
	logic signed [DATA_W-1:0] accel_q, prior_rate_q, clamped_q;
	logic                     first_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     sat_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic                     mul_en;
	logic                     slot_free;
	logic                     finish_go;

	logic signed [ACC_W-1:0]  prod_ext;
	logic [DATA_W-1:0]        prod_hi;
	logic [WRAP_W-1:0]        wrap_sub, wrap_nxt;
	logic signed [ACC_W-1:0]  accel_sum, u_sum;
	logic signed [DRV_W-1:0]  u40, low40, high40;
	logic signed [DATA_W-1:0] drive_nxt;
	logic                     sat_nxt;
	logic                     u_fits;

	assign prod_ext = {{(ACC_W-PSH_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:16]};
	assign prod_hi  = prod_q[63:32];

	assign wrap_sub = TWO_PI_Q16 << wrap_cnt_q;
	assign wrap_nxt = (wrap_q >= wrap_sub) ? wrap_q - wrap_sub : wrap_q;

	assign accel_sum = acc_q + prod_ext;
	assign u_sum     = acc_q - prod_ext;

	// Unclamped drive saturates to 40 bits, then is clamped to the limits
	assign u_fits = (&u_sum[ACC_W-1:DRV_W-1]) | ~(|u_sum[ACC_W-1:DRV_W-1]);
	assign low40  = {{(DRV_W-DATA_W){cfg.low[DATA_W-1]}}, cfg.low};
	assign high40 = {{(DRV_W-DATA_W){cfg.high[DATA_W-1]}}, cfg.high};

	always_comb begin
		if (u_fits) begin
			u40 = u_sum[DRV_W-1:0];
		end else begin
			u40 = u_sum[ACC_W-1] ? {1'b1, {(DRV_W-1){1'b0}}} : {1'b0, {(DRV_W-1){1'b1}}};
		end
		if (u40 < low40) begin
			drive_nxt = cfg.low;
			sat_nxt   = 1'b1;
		end else if (u40 > high40) begin
			drive_nxt = cfg.high;
			sat_nxt   = 1'b1;
		end else begin
			drive_nxt = u40[DATA_W-1:0];
			sat_nxt   = 1'b0;
		end
	end

	assign slot_free = !out_valid_q || pop;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_nxt = q_rdata.angular ? ST_CONV_REF : ST_FILT_POLE;
				end
			end
			ST_CONV_REF:  state_nxt = ST_CONV_POS;
			ST_CONV_POS:  state_nxt = ST_CONV_RATE;
			ST_CONV_RATE: state_nxt = ST_CONV_END;
			ST_CONV_END:  state_nxt = ST_WRAP;
			ST_WRAP: begin
				if (wrap_cnt_q == '0) begin
					state_nxt = ST_FILT_POLE;
				end
			end
			ST_FILT_POLE: state_nxt = ST_FILT_IN;
			ST_FILT_IN:   state_nxt = ST_FILT_SUM;
			ST_FILT_SUM:  state_nxt = ST_MUL_KP;
			ST_MUL_KP:    state_nxt = ST_MUL_KD;
			ST_MUL_KD:    state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: queue read and multiplier operands
	always_comb begin
		q_rd      = 1'b0;
		mul_en    = 1'b0;
		finish_go = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_IDLE: q_rd = q_valid;
			ST_CONV_REF: begin
				mul_en = 1'b1;
				mul_a  = {ref_q[DATA_W-1], ref_q};
				mul_b  = DEG2RAD_Q32;
			end
			ST_CONV_POS: begin
				mul_en = 1'b1;
				mul_a  = {pos_q[DATA_W-1], pos_q};
				mul_b  = DEG2RAD_Q32;
			end
			ST_CONV_RATE: begin
				mul_en = 1'b1;
				mul_a  = {rate_q[DATA_W-1], rate_q};
				mul_b  = DEG2RAD_Q32;
			end
			ST_FILT_POLE: begin
				mul_en = 1'b1;
				mul_a  = {16'b0, cfg.pole};
				mul_b  = {accel_q[DATA_W-1], accel_q};
			end
			ST_FILT_IN: begin
				mul_en = 1'b1;
				mul_a  = {2'b0, cfg.fin};
				mul_b  = {rate_q[DATA_W-1], rate_q} - {prior_rate_q[DATA_W-1], prior_rate_q};
			end
			ST_FILT_SUM: begin
				mul_en = 1'b1;
				mul_a  = {cfg.ki[DATA_W-1], cfg.ki};
				mul_b  = {err_q[DATA_W-1], err_q};
			end
			ST_MUL_KP: begin
				// no rate term on the first sample
				mul_en = 1'b1;
				mul_a  = {cfg.kp[DATA_W-1], cfg.kp};
				mul_b  = first_q ? '0 : {rate_q[DATA_W-1], rate_q};
			end
			ST_MUL_KD: begin
				mul_en = 1'b1;
				mul_a  = {cfg.kd[DATA_W-1], cfg.kd};
				mul_b  = {accel_q[DATA_W-1], accel_q};
			end
			ST_FINISH: finish_go = slot_free;
			default: begin
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					pos_q  <= q_rdata.pos;
					rate_q <= q_rdata.rate;
					ref_q  <= q_rdata.ref_v;
					err_q  <= q_rdata.lin_err;
				end
			end
			ST_CONV_POS:  ref_q <= prod_hi;
			ST_CONV_RATE: pos_q <= prod_hi;
			ST_CONV_END: begin
				rate_q   <= prod_hi;
				// true value is positive and below 2^28, so modular math is exact
				wrap_q   <= ref_q[WRAP_W-1:0] - pos_q[WRAP_W-1:0] + PI_Q16 + WRAP_BIAS;
			end
			ST_WRAP: begin
				wrap_q <= wrap_nxt;
				if (wrap_cnt_q == '0) begin
					err_q <= {{(DATA_W-WRAP_W){1'b0}}, wrap_nxt}
						- {{(DATA_W-WRAP_W){1'b0}}, PI_Q16};
				end
			end
			ST_FILT_IN:  acc_q <= prod_ext;
			ST_MUL_KP:   acc_q <= {{(ACC_W-DATA_W){clamped_q[DATA_W-1]}}, clamped_q} + prod_ext;
			ST_MUL_KD:   acc_q <= acc_q - prod_ext;
			ST_FINISH: begin
				if (finish_go) begin
					drive_q <= drive_nxt;
					sat_q   <= sat_nxt;
				end
			end
			default: begin
			end
		endcase
	end

	// Control and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wrap_cnt_q   <= '0;
			accel_q      <= '0;
			prior_rate_q <= '0;
			clamped_q    <= '0;
			first_q      <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CONV_END) begin
				wrap_cnt_q <= WRAP_TOP;
			end else if (state_q == ST_WRAP && wrap_cnt_q != '0) begin
				wrap_cnt_q <= wrap_cnt_q - 1'b1;
			end
			if (state_q == ST_FILT_SUM) begin
				accel_q <= first_q ? '0 : sat_to_32(accel_sum);
			end
			if (finish_go) begin
				clamped_q    <= drive_nxt;
				prior_rate_q <= rate_q;
				first_q      <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (pop) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	assign empty     = !out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

endmodule

`default_nettype wire

FILE: rtl/pid_velocity_form_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_velocity_form_antiwindup
// One channel of a velocity-form PID controller with back-calculation
// anti-windup, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A sample (measured value, measured rate, target) is pushed into a small
// queue and one drive command plus a saturation flag comes out of the result
// register for each sample, in order. A sequencer runs every product through
// one shared 33x33 multiplier (3 degree-to-radian conversions, 2 filter
// products, 3 gain products) and reduces the angle error with 9
// compare-subtract steps. The input queue (QUEUE_DEPTH samples) keeps
// accepting while the sequencer is busy, and a finished result waits in its
// register without stalling the next sample's work until it is needed. The
// user must write registers through the cfg port only while the block is
// idle; the block does not enforce this. cfg_ready is always high.
`default_nettype none

module pid_velocity_form_antiwindup
	import pvfa_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic signed [DATA_W-1:0] measured_value,
	input  wire logic signed [DATA_W-1:0] measured_rate,
	input  wire logic signed [DATA_W-1:0] target_value,
	output logic                          empty,
	input  wire logic                     pop,
	output logic signed [DATA_W-1:0]      drive,
	output logic                          saturated,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data
);

	cfg_t  cfg_q;
	logic  q_full, q_wr, q_rd, q_valid;
	item_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ki      <= '0;
			cfg_q.kp      <= '0;
			cfg_q.kd      <= '0;
			cfg_q.low     <= LOW_LIMIT_RST;
			cfg_q.high    <= HIGH_LIMIT_RST;
			cfg_q.pole    <= '0;
			cfg_q.fin     <= '0;
			cfg_q.angular <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KI:      cfg_q.ki      <= cfg_data;
				REG_KP:      cfg_q.kp      <= cfg_data;
				REG_KD:      cfg_q.kd      <= cfg_data;
				REG_LOW:     cfg_q.low     <= cfg_data;
				REG_HIGH:    cfg_q.high    <= cfg_data;
				REG_POLE:    cfg_q.pole    <= cfg_data[16:0];
				REG_FIN:     cfg_q.fin     <= cfg_data[30:0];
				REG_ANGULAR: cfg_q.angular <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pvfa_front u_front (
		.push           (push),
		.full           (full),
		.measured_value (measured_value),
		.measured_rate  (measured_rate),
		.target_value   (target_value),
		.angular        (cfg_q.angular),
		.q_full         (q_full),
		.q_wr           (q_wr),
		.q_wdata        (q_wdata)
	);

	pvfa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.valid   (q_valid)
	);

	pvfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_rd      (q_rd),
		.empty     (empty),
		.pop       (pop),
		.drive     (drive),
		.saturated (saturated)
	);

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the velocity-form PID channel with anti-windup.
// Samples go in through the push/full queue and are scored against a local
// Q16.16 predictor of the controller; results are popped and compared field
// by field. It runs directed corner cases and then randomized segments, each
// under a fresh register setting, phases differing in idle/stall profile.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
	import pvfa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned TAIL_CYCLES   = 40;
	localparam int unsigned SEG_ITEMS     = 75;
	localparam logic signed [63:0] DEG2RAD_W  = 64'(DEG2RAD_Q32);
	localparam logic signed [63:0] PI_W       = 64'(PI_Q16);
	localparam logic signed [63:0] TWO_PI_W   = 64'(TWO_PI_Q16);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     sat;
	} drive_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic signed [DATA_W-1:0] measured_value = '0;
	logic signed [DATA_W-1:0] measured_rate = '0;
	logic signed [DATA_W-1:0] target_value = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic signed [DATA_W-1:0] drive;
	logic                     saturated;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [DATA_W-1:0]        cfg_data = '0;

	// Shadow of the block's registers and loop state
	cfg_t                     shadow_cfg;
	logic signed [DATA_W-1:0] prior_rate;
	logic signed [DATA_W-1:0] filt_accel;
	logic signed [DRV_W-1:0]  unclamped_drive;
	logic signed [DATA_W-1:0] clamped_drive;
	logic                     first_sample;

	drive_result_t expected_drives[$];
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   tx_idle_pct = 0;
	int unsigned   rx_stall_pct = 0;

	pid_velocity_form_antiwindup i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.measured_value (measured_value),
		.measured_rate  (measured_rate),
		.target_value   (target_value),
		.empty          (empty),
		.pop            (pop),
		.drive          (drive),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	// exact product, floored to the given shift
	function automatic logic signed [63:0] mul_floor(input logic signed [63:0] a,
			input logic signed [63:0] b, input int unsigned sh);
		logic signed [127:0] prod;
		prod = a * b;
		return prod >>> sh;
	endfunction

	function automatic logic signed [63:0] clip(input logic signed [63:0] v,
			input int unsigned bits);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	task automatic predict_drive(input logic signed [DATA_W-1:0] meas,
			input logic signed [DATA_W-1:0] rate_in, input logic signed [DATA_W-1:0] tgt);
		logic signed [63:0] pos_v;
		logic signed [63:0] rate_v;
		logic signed [63:0] ref_v;
		logic signed [63:0] wrapped;
		logic signed [63:0] err;
		logic signed [63:0] accel;
		logic signed [63:0] rate_term;
		logic signed [63:0] incr;
		logic signed [63:0] u;
		logic signed [63:0] low_v;
		logic signed [63:0] high_v;
		drive_result_t      res;
		pos_v  = meas;
		rate_v = rate_in;
		ref_v  = tgt;
		low_v  = $signed(shadow_cfg.low);
		high_v = $signed(shadow_cfg.high);
		if (shadow_cfg.angular) begin
			pos_v   = mul_floor(pos_v, DEG2RAD_W, 32);
			rate_v  = mul_floor(rate_v, DEG2RAD_W, 32);
			ref_v   = mul_floor(ref_v, DEG2RAD_W, 32);
			wrapped = (ref_v - pos_v + PI_W) % TWO_PI_W;
			if (wrapped < 0) begin
				wrapped = wrapped + TWO_PI_W;
			end
			err = wrapped - PI_W;
		end else begin
			err = clip(ref_v - pos_v, 32);
		end
		if (first_sample) begin
			accel     = 0;
			rate_term = 0;
		end else begin
			accel = mul_floor(64'(shadow_cfg.pole), filt_accel, 16)
				+ mul_floor(64'(shadow_cfg.fin), rate_v - prior_rate, 16);
			accel     = clip(accel, 32);
			rate_term = rate_v;
		end
		incr = mul_floor($signed(shadow_cfg.ki), err, 16)
			- mul_floor($signed(shadow_cfg.kp), rate_term, 16)
			- mul_floor($signed(shadow_cfg.kd), accel, 16);
		u = clip(clamped_drive + incr, DRV_W);
		// low limit wins when the limits are crossed
		if (u < low_v) begin
			res.value = low_v[DATA_W-1:0];
			res.sat   = 1'b1;
		end else if (u > high_v) begin
			res.value = high_v[DATA_W-1:0];
			res.sat   = 1'b1;
		end else begin
			res.value = u[DATA_W-1:0];
			res.sat   = 1'b0;
		end
		prior_rate      = rate_v[DATA_W-1:0];
		filt_accel      = accel[DATA_W-1:0];
		unclamped_drive = u[DRV_W-1:0];
		clamped_drive   = res.value;
		first_sample    = 1'b0;
		expected_drives.push_back(res);
	endtask

	// ------------------------------------------------------------ result check

	always @(posedge clk) begin
		drive_result_t head;
		if (arst_n && pop && !empty) begin
			if (expected_drives.size() == 0) begin
				$error("unexpected result: drive %0d saturated %0d", drive, saturated);
				mismatch_count++;
			end else begin
				head = expected_drives.pop_front();
				if (drive !== head.value) begin
					$error("drive mismatch: expected %0d, actual %0d", head.value, drive);
					mismatch_count++;
				end
				if (saturated !== head.sat) begin
					$error("saturated mismatch: expected %0d, actual %0d", head.sat,
						saturated);
					mismatch_count++;
				end
			end
		end
		pop <= ($urandom_range(99) >= rx_stall_pct);
	end

	// ------------------------------------------------------------------ drivers

	task automatic send_sample(input logic signed [DATA_W-1:0] meas,
			input logic signed [DATA_W-1:0] rate_in, input logic signed [DATA_W-1:0] tgt);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push           <= 1'b1;
		measured_value <= meas;
		measured_rate  <= rate_in;
		target_value   <= tgt;
		do @(posedge clk); while (full);
		predict_drive(meas, rate_in, tgt);
	endtask

	// sender holds off until every outstanding result has been popped
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (expected_drives.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KI:      shadow_cfg.ki      = data;
			REG_KP:      shadow_cfg.kp      = data;
			REG_KD:      shadow_cfg.kd      = data;
			REG_LOW:     shadow_cfg.low     = data;
			REG_HIGH:    shadow_cfg.high    = data;
			REG_POLE:    shadow_cfg.pole    = data[16:0];
			REG_FIN:     shadow_cfg.fin     = data[30:0];
			REG_ANGULAR: shadow_cfg.angular = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// ------------------------------------------------------------ random values

	function automatic logic [DATA_W-1:0] rand_extreme();
		case ($urandom_range(3))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_sample_word();
		case ($urandom_range(9))
			0:       return rand_extreme();
			1, 2:    return $urandom;
			3, 4, 5: return $urandom_range(0, 1 << 20) - (1 << 19);
			default: begin
				// +-400 degrees in angular mode, +-32.0 otherwise
				if (shadow_cfg.angular) begin
					return $urandom_range(0, 52428800) - 26214400;
				end
				return $urandom_range(0, 1 << 22) - (1 << 21);
			end
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_gain();
		case ($urandom_range(7))
			0:       return rand_extreme();
			1:       return $urandom;
			default: return $urandom_range(0, 1 << 18) - (1 << 17);
		endcase
	endfunction

	task automatic randomize_config();
		logic [DATA_W-1:0] lim;
		logic [DATA_W-1:0] lim2;
		write_reg(REG_KI, rand_gain());
		write_reg(REG_KP, rand_gain());
		write_reg(REG_KD, rand_gain());
		lim  = $urandom_range(1 << 14, 1 << 22);
		lim2 = $urandom_range(1 << 14, 1 << 22);
		case ($urandom_range(7))
			0: begin
				write_reg(REG_LOW, 32'h8000_0000);
				write_reg(REG_HIGH, 32'h7fff_ffff);
			end
			1: begin
				write_reg(REG_LOW, lim);
				write_reg(REG_HIGH, -lim2);
			end
			2: begin
				write_reg(REG_LOW, $urandom);
				write_reg(REG_HIGH, $urandom);
			end
			default: begin
				write_reg(REG_LOW, -lim);
				write_reg(REG_HIGH, lim2);
			end
		endcase
		case ($urandom_range(5))
			0:       write_reg(REG_POLE, 32'd0);
			1:       write_reg(REG_POLE, 32'd131071);
			2:       write_reg(REG_POLE, $urandom);
			default: write_reg(REG_POLE, $urandom_range(40000, 65536));
		endcase
		case ($urandom_range(5))
			0:       write_reg(REG_FIN, 32'd0);
			1:       write_reg(REG_FIN, 32'h7fff_ffff);
			2:       write_reg(REG_FIN, $urandom);
			default: write_reg(REG_FIN, $urandom_range(0, 1 << 22));
		endcase
		// upper bits random, only bit 0 is kept
		write_reg(REG_ANGULAR, $urandom);
	endtask

	// ------------------------------------------------------------------- tests

	// rate term and filter must stay out of the first sample after reset
	task automatic test_first_sample();
		write_reg(REG_KI, 32'd65536);
		write_reg(REG_KP, 32'd32768);
		write_reg(REG_KD, 32'd16384);
		write_reg(REG_POLE, 32'd60000);
		write_reg(REG_FIN, 32'd400000);
		write_reg(REG_ANGULAR, 32'd0);
		send_sample(32'sd0, 32'sd655360, 32'sd131072);
		send_sample(32'sd65536, -32'sd655360, 32'sd131072);
		send_sample(32'sd0, 32'sd0, 32'sd0);
	endtask

	task automatic test_linear_extremes();
		wait_idle();
		write_reg(REG_LOW, 32'h8000_0000);
		write_reg(REG_HIGH, 32'h7fff_ffff);
		// error saturates both ways
		send_sample(32'sh8000_0000, 32'sd0, 32'sh7fff_ffff);
		send_sample(32'sh7fff_ffff, 32'sd0, 32'sh8000_0000);
		send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_sample(-32'sd1, -32'sd1, -32'sd1);
	endtask

	task automatic test_filter_overflow();
		wait_idle();
		write_reg(REG_POLE, 32'd131071);
		write_reg(REG_FIN, 32'h7fff_ffff);
		write_reg(REG_KD, 32'd65536);
		send_sample(32'sd0, 32'sh8000_0000, 32'sd0);
		send_sample(32'sd0, 32'sh7fff_ffff, 32'sd0);
		send_sample(32'sd0, 32'sh8000_0000, 32'sd0);
		send_sample(32'sd0, 32'sh7fff_ffff, 32'sd0);
	endtask

	task automatic test_drive_overflow();
		wait_idle();
		write_reg(REG_KI, 32'h7fff_ffff);
		write_reg(REG_KP, 32'd0);
		write_reg(REG_KD, 32'd0);
		send_sample(32'sh8000_0000, 32'sd0, 32'sh7fff_ffff);
		send_sample(32'sh8000_0000, 32'sd0, 32'sh7fff_ffff);
		wait_idle();
		write_reg(REG_KI, 32'h8000_0000);
		send_sample(32'sh8000_0000, 32'sd0, 32'sh7fff_ffff);
		send_sample(32'sh8000_0000, 32'sd0, 32'sh7fff_ffff);
	endtask

	task automatic test_crossed_limits();
		wait_idle();
		write_reg(REG_KI, 32'd65536);
		write_reg(REG_LOW, 32'd100000);
		write_reg(REG_HIGH, -32'd100000);
		send_sample(32'sd0, 32'sd0, 32'sd655360);
		send_sample(32'sd0, 32'sd0, -32'sd655360);
		send_sample(32'sd0, 32'sd0, 32'sd0);
	endtask

	// degree conversion and error wrap, including the extreme angles
	task automatic test_angular();
		wait_idle();
		write_reg(REG_ANGULAR, 32'd1);
		write_reg(REG_LOW, LOW_LIMIT_RST);
		write_reg(REG_HIGH, HIGH_LIMIT_RST);
		write_reg(REG_KI, 32'd65536);
		write_reg(REG_KP, 32'd6554);
		write_reg(REG_KD, 32'd655);
		write_reg(REG_POLE, 32'd50000);
		write_reg(REG_FIN, 32'd200000);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
		send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
		send_sample(32'sd11796480, 32'sd0, -32'sd11796480);
		send_sample(32'sd0, 32'sd5898240, 32'sd23527424);
		send_sample(-32'sd1, -32'sd1, -32'sd1);
	endtask

	task automatic test_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
		for (int seg = 0; seg < 3; seg++) begin
			wait_idle();
			tx_idle_pct  = tx_pct;
			rx_stall_pct = rx_pct;
			randomize_config();
			repeat (SEG_ITEMS) begin
				send_sample(rand_sample_word(), rand_sample_word(), rand_sample_word());
			end
		end
	endtask

	initial begin
		shadow_cfg      = '0;
		shadow_cfg.low  = LOW_LIMIT_RST;
		shadow_cfg.high = HIGH_LIMIT_RST;
		prior_rate      = '0;
		filt_accel      = '0;
		unclamped_drive = '0;
		clamped_drive   = '0;
		first_sample    = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_sample();
		test_linear_extremes();
		test_filter_overflow();
		test_drive_overflow();
		test_crossed_limits();
		test_angular();

		test_random_phase(0, 0);
		test_random_phase(68, 0);
		test_random_phase(0, 68);
		test_random_phase(7, 7);

		wait_idle();
		rx_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_drives.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/pvfa_pkg.sv
rtl/pvfa_front.sv
rtl/pvfa_queue.sv
rtl/pvfa_back.sv
rtl/pid_velocity_form_antiwindup.sv
dv/testbench.sv
